@@ rtl/core/mtq_pkg.sv @@
// shared constants and types for the max tracking queue
package mtq_pkg;

    // default number of store entries
    localparam int DEPTH_DEF = 1024;

    // width of one queued value; an entry holds value and running max
    localparam int DATA_W  = 32;
    localparam int ENTRY_W = 2 * DATA_W;

    // item kinds
    localparam logic [1:0] KIND_ENQ    = 2'd0;
    localparam logic [1:0] KIND_DEQ    = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_XFER,
        S_DEQ_RD,
        S_DEQ_VAL,
        S_DEQ_MAX,
        S_REPORT
    } t_state;

endpackage

@@ rtl/core/mtq_ram.sv @@
// single port-pair entry store with registered read
module mtq_ram #(
    parameter int DEPTH = mtq_pkg::DEPTH_DEF,
    parameter int WIDTH = mtq_pkg::ENTRY_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/max_tracking_queue.sv @@
// fifo of signed values built from two stacks in one store, reporting the maximum
//
//  channel   ports                                        handshake
//  -------   -------------------------------------------  ------------------------------
//  item in   i_kind, i_value                              taken when start && !busy
//  result    o_dequeued, o_largest, o_is_empty,           o_done high for one cycle,
//            o_underflow, o_overflow                      taken at the edge ending it
//
//  enqueue and status: busy through the report state after the accept, result in the cycle after that
//  dequeue from a filled out-stack: busy for a store read of the value, then of the new top's
//  running max (skipped if the out-stack is left empty), then report; result in the following cycle
//  dequeue on an empty out-stack first moves all in-stack values, one per cycle through
//  the store's read and write ports, then pops the new out-stack top
//  reset is synchronous, active low; the store itself is not cleared, only the counts, state and strobe
//  the receiver cannot stall: each result is shown once and the next item may start then
module max_tracking_queue #(
    parameter int DEPTH = mtq_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_kind,
    input  logic signed [mtq_pkg::DATA_W-1:0] i_value,
    output logic                              o_done,
    output logic signed [mtq_pkg::DATA_W-1:0] o_dequeued,
    output logic signed [mtq_pkg::DATA_W-1:0] o_largest,
    output logic                              o_is_empty,
    output logic                              o_underflow,
    output logic                              o_overflow
);

    localparam int DW = mtq_pkg::DATA_W;
    localparam int EW = mtq_pkg::ENTRY_W;
    localparam int AW = $clog2(DEPTH);
    // counts run from 0 to DEPTH inclusive
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    // sequencer and stack state
    mtq_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_in_cnt, n_in_cnt;      // values on the in-stack (bottom at entry 0)
    logic [CW-1:0]   r_out_cnt, n_out_cnt;    // values on the out-stack (bottom at DEPTH-1)
    logic signed [DW-1:0] r_in_max, n_in_max;   // running max at the in-stack top
    logic signed [DW-1:0] r_out_max, n_out_max; // running max at the out-stack top
    logic signed [DW-1:0] r_deq, n_deq;
    logic            r_under, n_under;
    logic            r_over, n_over;

    // result registers
    logic                 r_done;
    logic signed [DW-1:0] r_dequeued;
    logic signed [DW-1:0] r_largest;
    logic                 r_is_empty;
    logic                 r_underflow;
    logic                 r_overflow;

    // store access
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [EW-1:0] mem_rdata;

    // derived values
    logic [CW-1:0]        w_total;
    logic                 w_full;
    logic [CW-1:0]        w_in_top;     // in-stack top entry, in_cnt - 1
    logic [CW-1:0]        w_out_top;    // out-stack top entry, DEPTH - out_cnt
    logic [CW-1:0]        w_out_free;   // next free out-stack entry, DEPTH - 1 - out_cnt
    logic signed [DW-1:0] w_enq_max;
    logic signed [DW-1:0] w_xfer_val;
    logic signed [DW-1:0] w_xfer_max;
    logic                 w_empty;
    logic signed [DW-1:0] w_largest;

    mtq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (EW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign w_total    = r_in_cnt + r_out_cnt;
    assign w_full     = (w_total == DEPTH_C);
    assign w_in_top   = r_in_cnt - ONE_C;
    assign w_out_top  = DEPTH_C - r_out_cnt;
    assign w_out_free = DEPTH_C - ONE_C - r_out_cnt;

    // running max for a value pushed onto the in-stack
    assign w_enq_max  = ((r_in_cnt != '0) && (r_in_max > i_value)) ? r_in_max : i_value;

    // value read off the in-stack during a transfer, and its new running max
    assign w_xfer_val = mem_rdata[DW-1:0];
    assign w_xfer_max = ((r_out_cnt != '0) && (r_out_max > w_xfer_val)) ?
                        r_out_max : w_xfer_val;

    // queue maximum is the larger of the two stack-top maxima, zero when the queue is empty
    assign w_empty = (r_in_cnt == '0) && (r_out_cnt == '0);
    always_comb begin
        priority if (w_empty) begin
            w_largest = '0;
        end else if (r_in_cnt == '0) begin
            w_largest = r_out_max;
        end else if (r_out_cnt == '0) begin
            w_largest = r_in_max;
        end else begin
            w_largest = (r_out_max > r_in_max) ? r_out_max : r_in_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
        end else begin
            r_in_cnt  <= n_in_cnt;
            r_out_cnt <= n_out_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_max  <= n_in_max;
        r_out_max <= n_out_max;
        r_deq     <= n_deq;
        r_under   <= n_under;
        r_over    <= n_over;
    end

    // next state, counts and store accesses
    always_comb begin
        n_state   = r_state;
        n_in_cnt  = r_in_cnt;
        n_out_cnt = r_out_cnt;
        n_in_max  = r_in_max;
        n_out_max = r_out_max;
        n_deq     = r_deq;
        n_under   = r_under;
        n_over    = r_over;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;

        unique case (r_state)
            mtq_pkg::S_IDLE: begin
                if (start) begin
                    n_deq   = '0;
                    n_under = 1'b0;
                    n_over  = 1'b0;
                    priority if (i_kind == mtq_pkg::KIND_ENQ) begin
                        if (w_full) begin
                            // store full: item dropped
                            n_over = 1'b1;
                        end else begin
                            mem_we    = 1'b1;
                            mem_waddr = r_in_cnt[AW-1:0];
                            mem_wdata = {w_enq_max, i_value};
                            n_in_max  = w_enq_max;
                            n_in_cnt  = r_in_cnt + ONE_C;
                        end
                        n_state = mtq_pkg::S_REPORT;
                    end else if (i_kind == mtq_pkg::KIND_DEQ) begin
                        priority if (r_out_cnt != '0) begin
                            // pop the out-stack top
                            mem_raddr = w_out_top[AW-1:0];
                            n_out_cnt = r_out_cnt - ONE_C;
                            n_state   = mtq_pkg::S_DEQ_VAL;
                        end else if (r_in_cnt != '0) begin
                            // out-stack empty: start moving the in-stack across
                            mem_raddr = w_in_top[AW-1:0];
                            n_in_cnt  = w_in_top;
                            n_state   = mtq_pkg::S_XFER;
                        end else begin
                            // nothing queued
                            n_under = 1'b1;
                            n_state = mtq_pkg::S_REPORT;
                        end
                    end else begin
                        // status only, and the unused kind
                        n_state = mtq_pkg::S_REPORT;
                    end
                end
            end

            mtq_pkg::S_XFER: begin
                // push the value just read onto the out-stack; in and out entries
                // never overlap, so the next read goes out in the same cycle
                mem_we    = 1'b1;
                mem_waddr = w_out_free[AW-1:0];
                mem_wdata = {w_xfer_max, w_xfer_val};
                n_out_max = w_xfer_max;
                n_out_cnt = r_out_cnt + ONE_C;
                if (r_in_cnt != '0) begin
                    mem_raddr = w_in_top[AW-1:0];
                    n_in_cnt  = w_in_top;
                end else begin
                    n_state = mtq_pkg::S_DEQ_RD;
                end
            end

            mtq_pkg::S_DEQ_RD: begin
                mem_raddr = w_out_top[AW-1:0];
                n_out_cnt = r_out_cnt - ONE_C;
                n_state   = mtq_pkg::S_DEQ_VAL;
            end

            mtq_pkg::S_DEQ_VAL: begin
                n_deq = mem_rdata[DW-1:0];
                if (r_out_cnt != '0) begin
                    // fetch running max of the new top
                    mem_raddr = w_out_top[AW-1:0];
                    n_state   = mtq_pkg::S_DEQ_MAX;
                end else begin
                    n_state = mtq_pkg::S_REPORT;
                end
            end

            mtq_pkg::S_DEQ_MAX: begin
                n_out_max = mem_rdata[EW-1:DW];
                n_state   = mtq_pkg::S_REPORT;
            end

            mtq_pkg::S_REPORT: begin
                n_state = mtq_pkg::S_IDLE;
            end

            default: begin
                n_state = mtq_pkg::S_IDLE;
            end
        endcase
    end

    // result strobe and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == mtq_pkg::S_REPORT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == mtq_pkg::S_REPORT) begin
            r_dequeued  <= r_deq;
            r_largest   <= w_largest;
            r_is_empty  <= w_empty;
            r_underflow <= r_under;
            r_overflow  <= r_over;
        end
    end

    assign busy        = (r_state != mtq_pkg::S_IDLE);
    assign o_done      = r_done;
    assign o_dequeued  = r_dequeued;
    assign o_largest   = r_largest;
    assign o_is_empty  = r_is_empty;
    assign o_underflow = r_underflow;
    assign o_overflow  = r_overflow;

`ifndef SYNTHESIS
    // the two stacks never claim more entries than the store has
    a_no_overcommit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_total <= DEPTH_C))
        else $error("stack counts exceed store depth");

    // a result is shown only once the sequencer is back to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // underflow only on an empty queue and with no value returned
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_underflow) |-> (o_is_empty && (o_dequeued == '0) && !o_overflow))
        else $error("underflow with a non-empty queue");

    // a dropped enqueue means the store is full, so never empty
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_overflow) |-> !o_is_empty)
        else $error("overflow on an empty queue");

    // the transfer only runs while the out-stack is being filled from the in-stack
    a_xfer_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mtq_pkg::S_XFER) |=> (r_out_cnt == $past(r_out_cnt) + ONE_C))
        else $error("transfer did not push a value");
`endif

endmodule
